// File: hw/rtl/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants of the single-server wait queue
// Request, result, slot and command layouts, pointer step helper.
// ----------------------------------------------------------------------------
package ssq_pkg;

	localparam int DEPTH    = 128;
	localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = PTR_W + 1;
	localparam int ID_W     = 16;
	localparam int TICK_W   = 32;
	localparam int SVC_W    = 4;
	localparam int SUM_W    = 48;
	localparam int QCOUNT_W = 7;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef struct packed {
		logic             arrive;
		logic [SVC_W-1:0] service_len;
	} tick_t;

	typedef struct packed {
		logic                start_valid;
		logic [ID_W-1:0]     start_id;
		logic [TICK_W-1:0]   start_wait;
		logic [SUM_W-1:0]    wait_total;
		logic [SVC_W-1:0]    busy_left;
		logic [QCOUNT_W-1:0] queue_count;
		logic                overflow;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] arrival;
		logic [SVC_W-1:0]  service;
	} slot_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
		logic accum;
	} ssq_cmd_t;

	// Step a ring pointer, wrapping at the last slot
	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] nxt;
		if (p == PTR_W'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = p + 1'b1;
		end
		return nxt;
	endfunction

endpackage

// File: hw/rtl/ssq_ctrl.sv
// ----------------------------------------------------------------------------
// ssq_ctrl: sequencer of the wait queue
// Steps each request through read, execute and accumulate, then holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module ssq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output ssq_pkg::ssq_cmd_t cmd
);
	import ssq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_ACCUM,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						state_q <= ST_READ;
						ready_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					state_q <= ST_OUT;
					valid_q <= 1'b1;
				end
				ST_OUT: begin
					if (result_ready) begin
						state_q <= ST_IDLE;
						valid_q <= 1'b0;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign tick_ready   = ready_q;
	assign result_valid = valid_q;

	assign cmd.capture = ready_q && tick_valid;
	assign cmd.read    = (state_q == ST_READ);
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.accum   = (state_q == ST_ACCUM);

endmodule

// File: hw/rtl/ssq_datapath.sv
// ----------------------------------------------------------------------------
// ssq_datapath: slot ring, pointers, server countdown and wait totals
// Enqueue, dequeue with same-tick bypass, wait subtract and saturating sum.
// ----------------------------------------------------------------------------
module ssq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ssq_pkg::ssq_cmd_t cmd,
	input  ssq_pkg::tick_t    tick,
	output ssq_pkg::result_t  result
);
	import ssq_pkg::*;

	slot_t mem [DEPTH];

	logic              arrive_q;
	logic [SVC_W-1:0]  svc_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [TICK_W-1:0] tick_q;
	logic [ID_W-1:0]   id_q;
	logic [SVC_W-1:0]  rem_q;
	logic [SUM_W-1:0]  sum_q;
	slot_t             rd_q;

	logic              sv_q;
	logic [ID_W-1:0]   sid_q;
	logic [TICK_W-1:0] swait_q;
	logic              ovf_q;

	logic [PTR_W-1:0]  nt;
	logic [PTR_W-1:0]  nh;
	logic              full;
	logic              do_enq;
	logic [PTR_W-1:0]  tail_n;
	logic              do_deq;
	slot_t             new_slot;
	slot_t             head_slot;
	logic [SUM_W:0]    sum_ext;
	logic [CNT_W-1:0]  cnt;

	always_comb begin
		nt       = ptr_adv(tail_q);
		nh       = ptr_adv(head_q);
		full     = (nt == head_q);
		do_enq   = arrive_q && !full;
		tail_n   = do_enq ? nt : tail_q;
		do_deq   = (rem_q == '0) && (head_q != tail_n);
		new_slot = '{id: id_q, arrival: tick_q, service: svc_q};
		// Empty ring before this tick: the head is the slot just written
		head_slot = (head_q == tail_q) ? new_slot : rd_q;
		sum_ext   = {1'b0, sum_q} + {{(SUM_W - TICK_W + 1){1'b0}}, swait_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_enq) begin
			mem[nt] <= new_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_q <= mem[nh];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			arrive_q <= tick.arrive;
			svc_q    <= tick.service_len;
		end
		if (cmd.exec) begin
			sv_q    <= do_deq;
			sid_q   <= do_deq ? head_slot.id : '0;
			swait_q <= do_deq ? (tick_q - head_slot.arrival) : '0;
			ovf_q   <= arrive_q && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			tick_q <= '0;
			id_q   <= '0;
			rem_q  <= '0;
			sum_q  <= '0;
		end else begin
			if (cmd.exec) begin
				tail_q <= tail_n;
				tick_q <= tick_q + 1'b1;
				if (do_enq) begin
					id_q <= id_q + 1'b1;
				end
				if (rem_q != '0) begin
					rem_q <= rem_q - 1'b1;
				end else if (do_deq) begin
					rem_q  <= head_slot.service;
					head_q <= nh;
				end
			end
			if (cmd.accum) begin
				// Stick at the top once the sum carries out
				sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
			end
		end
	end

	always_comb begin
		if (tail_q >= head_q) begin
			cnt = {1'b0, tail_q} - {1'b0, head_q};
		end else begin
			cnt = {1'b0, tail_q} + CNT_W'(DEPTH) - {1'b0, head_q};
		end
	end

	assign result.start_valid = sv_q;
	assign result.start_id    = sid_q;
	assign result.start_wait  = swait_q;
	assign result.wait_total  = sum_q;
	assign result.busy_left   = rem_q;
	assign result.queue_count = QCOUNT_W'(cnt);
	assign result.overflow    = ovf_q;

endmodule

// File: hw/rtl/single_server_wait_queue_core.sv
// ----------------------------------------------------------------------------
// single_server_wait_queue_core: single-server waiting line, one tick a request
// Circular slot queue with service countdown and saturating wait total.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  tick      in         tick_valid / tick_ready      ssq_pkg::tick_t
//  result    out        result_valid / result_ready  ssq_pkg::result_t
//
//  A request passes through accept, slot read, execute, accumulate and result
//  handoff, set by the sequencer and the registered read port of the slot
//  memory.
//  A stalled result holds its register; no new request is taken meanwhile.
//  arst_n clears pointers, tick, id, countdown and total; the slot memory
//  needs no clearing pass.
// ----------------------------------------------------------------------------
module single_server_wait_queue_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_ready,
	input  ssq_pkg::tick_t   tick,
	output logic             result_valid,
	input  logic             result_ready,
	output ssq_pkg::result_t result
);
	import ssq_pkg::*;

	ssq_cmd_t cmd;

	ssq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	ssq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.tick   (tick),
		.result (result)
	);

endmodule
